/* rtl/kss_pkg.sv */
// ----------------------------------------------------------------------------
// kss_pkg: shared types and constants for the plucked string voices
// Payload structs, request codes, register map and LFSR constants.
// ----------------------------------------------------------------------------
`default_nettype none
package kss_pkg;
    localparam int VOICE_COUNT_DEF   = 16;
    localparam int MAX_DELAY_LEN_DEF = 1024;
    localparam int RATE_W            = 17;
    localparam logic [RATE_W-1:0] RATE_RESET = 17'd44100;
    localparam logic [15:0] MIN_TICK_FREQ = 16'd880;
    localparam logic [31:0] LFSR_SEED = 32'hACE1ACE1;
    localparam logic [31:0] LFSR_MASK = 32'h80200003;
    localparam logic [0:0] REQ_PLUCK = 1'b0;
    localparam logic [0:0] REQ_TICK  = 1'b1;
    localparam logic [0:0] REG_SAMPLE_RATE = 1'b0;

    typedef struct packed {
        logic [0:0]  req_type;
        logic [3:0]  voice;
        logic [15:0] freq;
        logic [15:0] feedback;
        logic [15:0] amp;
    } t_req;

    typedef struct packed {
        logic [3:0]         voice_out;
        logic signed [15:0] string_sample;
        logic signed [15:0] sample_out;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_PLUCK, S_RD, S_WAIT, S_CALC, S_WR, S_OUT
    } t_state;

    function automatic logic [31:0] lfsr_step(input logic [31:0] s);
        return s[0] ? ((s >> 1) ^ LFSR_MASK) : (s >> 1);
    endfunction
endpackage
`default_nettype wire

/* rtl/kss_ram.sv */
// ----------------------------------------------------------------------------
// kss_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module kss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

/* rtl/kss_fifo.sv */
// ----------------------------------------------------------------------------
// kss_fifo: small register queue
// Two-entry queue used for the request and result channels.
// ----------------------------------------------------------------------------
`default_nettype none
module kss_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);
    logic [WIDTH-1:0] r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic w, rd;
    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_data  = r_mem[r_rp];
    assign w  = i_push && !o_full;
    assign rd = i_pop && !o_empty;
    always_ff @(posedge i_clk) begin
        if (w) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w} - {1'b0, rd};
        end
    end
endmodule
`default_nettype wire

/* rtl/kss_engine.sv */
// ----------------------------------------------------------------------------
// kss_engine: string update engine
// Divides for the string length, fills delay lines, runs ticks.
// ----------------------------------------------------------------------------
`default_nettype none
module kss_engine
    import kss_pkg::*;
#(
    parameter int VOICE_COUNT   = VOICE_COUNT_DEF,
    parameter int MAX_DELAY_LEN = MAX_DELAY_LEN_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [RATE_W-1:0] i_rate,
    input  wire logic              i_req_valid,
    input  wire t_req              i_req,
    output logic                   o_req_take,
    output logic                   o_rsp_push,
    output t_rsp                   o_rsp,
    input  wire logic              i_rsp_full
);
    localparam int LW = $clog2(MAX_DELAY_LEN);
    localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int AW = $clog2(VOICE_COUNT * MAX_DELAY_LEN);
    localparam int NW = RATE_W + 4;

    t_state r_state, n_state;
    t_req r_req;
    logic [31:0] r_lfsr;
    logic [LW-1:0] r_index [VOICE_COUNT];
    logic [NW-1:0] r_quo, r_rem;
    logic [4:0] r_bit;
    logic [LW:0] r_len, r_cnt;
    logic [LW-1:0] r_idx, r_nxt;
    logic signed [15:0] r_cur, r_new;
    logic signed [15:0] r_scl;
    logic r_phase;

    logic [15:0] f;
    logic [NW:0] trial;
    logic [LW:0] len_c, len1;
    logic [LW-1:0] old_idx, idx_c;
    logic we;
    logic [AW-1:0] addr;
    logic [15:0] wdata, rdata;
    logic [VW-1:0] vsel;
    logic vok, work;
    logic signed [33:0] prod_a, prod_f;
    logic [31:0] lf_next;

    assign vsel = r_req.voice[VW-1:0];
    assign vok  = {28'd0, r_req.voice} < 32'(VOICE_COUNT);
    assign work = vok && (r_req.freq >= MIN_TICK_FREQ);
    assign f    = (r_req.freq == 16'd0) ? 16'd16 : r_req.freq;
    assign trial = {r_rem, r_quo[NW-1]} ;
    assign len_c = (r_quo > NW'(MAX_DELAY_LEN)) ? (LW+1)'(MAX_DELAY_LEN) : r_quo[LW:0];
    assign len1  = (r_len == '0) ? (LW+1)'(1) : r_len;
    assign old_idx = r_index[vsel];
    assign idx_c = ({1'b0, old_idx} >= len1) ? '0 : old_idx;
    assign lf_next = lfsr_step(r_lfsr);

    kss_ram #(.WIDTH(16), .DEPTH(VOICE_COUNT * MAX_DELAY_LEN)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_addr(addr), .i_wdata(wdata), .o_rdata(rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_req_valid) n_state = S_DIV;
            S_DIV: begin
                if (r_bit == 5'd0) begin
                    if (r_req.req_type == REQ_PLUCK) n_state = vok ? S_PLUCK : S_IDLE;
                    else n_state = work ? S_RD : S_OUT;
                end
            end
            S_PLUCK: if (r_cnt >= r_len) n_state = S_IDLE;
            S_RD:   if (r_phase) n_state = S_WAIT;
            S_WAIT: n_state = S_CALC;
            S_CALC: n_state = S_WR;
            S_WR:   n_state = S_OUT;
            S_OUT:  if (!i_rsp_full) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_req_take = (r_state == S_IDLE) && i_req_valid;
        o_rsp_push = (r_state == S_OUT) && !i_rsp_full;
        o_rsp.voice_out = r_req.voice;
        o_rsp.string_sample = work ? r_cur : 16'sd0;
        o_rsp.sample_out = work ? r_scl : 16'sd0;
        we = 1'b0;
        addr = AW'({vsel, idx_c});
        wdata = r_new;
        case (r_state)
            S_PLUCK: begin
                we = r_cnt < r_len;
                addr = AW'(vsel) * AW'(MAX_DELAY_LEN) + AW'(r_cnt[LW-1:0]);
                wdata = lf_next[31:16] ^ 16'h8000;
            end
            S_RD, S_WAIT: begin
                addr = AW'(vsel) * AW'(MAX_DELAY_LEN) + AW'(r_phase ? r_nxt : idx_c);
            end
            S_WR: begin
                we = 1'b1;
                addr = AW'(vsel) * AW'(MAX_DELAY_LEN) + AW'(r_idx);
            end
            default: ;
        endcase
    end

    assign prod_f = 34'(($signed({r_cur[15], r_cur}) + $signed({rdata[15], rdata})))
                    * $signed({18'd0, r_req.feedback});
    assign prod_a = $signed({{18{r_cur[15]}}, r_cur}) * $signed({18'd0, r_req.amp});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lfsr <= LFSR_SEED;
            for (int i = 0; i < VOICE_COUNT; i++) r_index[i] <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    r_req <= i_req;
                    r_quo <= NW'({i_rate, 4'd0});
                    r_rem <= '0;
                    r_bit <= 5'(NW);
                    r_cnt <= '0;
                    r_phase <= 1'b0;
                end
                S_DIV: begin
                    // one restoring-division bit per cycle
                    if (r_bit != 5'd0) begin
                        r_bit <= r_bit - 5'd1;
                        if (trial >= (NW+1)'(f)) begin
                            r_rem <= NW'(trial - (NW+1)'(f));
                            r_quo <= {r_quo[NW-2:0], 1'b1};
                        end else begin
                            r_rem <= trial[NW-1:0];
                            r_quo <= {r_quo[NW-2:0], 1'b0};
                        end
                    end else begin
                        r_len <= len_c;
                    end
                end
                S_PLUCK: begin
                    if (r_cnt < r_len) begin
                        r_cnt <= r_cnt + 1'b1;
                        r_lfsr <= lf_next;
                    end
                end
                S_RD: begin
                    if (!r_phase) begin
                        r_idx <= idx_c;
                        r_nxt <= ({1'b0, idx_c} + 1'b1 >= len1) ? '0 : idx_c + 1'b1;
                    end else begin
                        // current entry arrives while the next one is addressed
                        r_cur <= rdata;
                    end
                    r_phase <= 1'b1;
                end
                S_CALC: begin
                    r_new <= prod_f[32:17];
                    if ($signed(prod_a[33:12]) > 22'sd32767) r_scl <= 16'sh7fff;
                    else if ($signed(prod_a[33:12]) < -22'sd32768) r_scl <= -16'sh8000;
                    else r_scl <= prod_a[27:12];
                end
                S_WR: r_index[vsel] <= r_nxt;
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

/* rtl/karplus_strong_string_voices_core.sv */
// ----------------------------------------------------------------------------
// karplus_strong_string_voices_core: multi-voice plucked string
// Request queue, string engine and result queue with an APB register port.
// ----------------------------------------------------------------------------
// A front queue takes pluck and tick beats; the engine works one at a time.
// Each item is taken from the queue, then a restoring division finds the
// string length (21 quotient bits and a final clamp step). A working tick then
// makes two delay-line reads, waits, multiplies and writes back through the
// single RAM port, then pushes its result; a tick below the frequency threshold
// or for a voice out of range pushes its zero result right after the division.
// A pluck fills the voice's delay line with LFSR noise, one entry at a time.
// A full result queue holds the engine at the push. Results leave through a
// two-beat result queue. No clearing pass is needed.
`default_nettype none
module karplus_strong_string_voices_core
    import kss_pkg::*;
#(
    parameter int VOICE_COUNT   = VOICE_COUNT_DEF,
    parameter int MAX_DELAY_LEN = MAX_DELAY_LEN_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire t_req        i_req,
    input  wire logic        pop,
    output logic             empty,
    output t_rsp             o_rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    logic [RATE_W-1:0] r_rate;
    logic req_empty, take, rsp_push, rsp_full;
    t_req req_q;
    t_rsp rsp_d;

    assign pready = 1'b1;
    assign prdata = (paddr[1:1] == REG_SAMPLE_RATE) ? {15'd0, r_rate} : 32'd0;

    // hold the sample rate register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RESET;
        end else if (psel && penable && pwrite && paddr[1:1] == REG_SAMPLE_RATE) begin
            r_rate <= pwdata[RATE_W-1:0];
        end
    end

    kss_fifo #(.WIDTH($bits(t_req))) u_req_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_data(i_req),
        .o_full(full), .i_pop(take), .o_data(req_q), .o_empty(req_empty)
    );

    kss_engine #(.VOICE_COUNT(VOICE_COUNT), .MAX_DELAY_LEN(MAX_DELAY_LEN)) u_eng (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_rate(r_rate),
        .i_req_valid(!req_empty), .i_req(req_q), .o_req_take(take),
        .o_rsp_push(rsp_push), .o_rsp(rsp_d), .i_rsp_full(rsp_full)
    );

    kss_fifo #(.WIDTH($bits(t_rsp))) u_rsp_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(rsp_push), .i_data(rsp_d),
        .o_full(rsp_full), .i_pop(pop), .o_data(o_rsp), .o_empty(empty)
    );
endmodule
`default_nettype wire
